/* hdl/rqr_pkg.sv */
// Package for the ready queue with removal: payload structs, command codes,
// state encoding and the link RAM control group. No dependencies.
package rqr_pkg;

  localparam int MAX_TASKS_DEF = 64;
  localparam int CMD_W         = 2;
  localparam int TASK_ID_W     = 6;
  localparam int COUNT_OUT_W   = 7;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [TASK_ID_W-1:0] task_id;
  } rqr_in_t;

  typedef struct packed {
    logic                   accepted;
    logic                   popped_valid;
    logic [TASK_ID_W-1:0]   popped_id;
    logic [COUNT_OUT_W-1:0] queue_count;
  } rqr_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FIX
  } rqr_state_t;

  typedef struct packed {
    logic rd_en;
    logic next_we;
    logic prev_we;
  } rqr_ram_ctl_t;

endpackage

/* hdl/rqr_link_ram.sv */
// Link storage for the ready queue: next-link RAM and prev-link RAM, the
// latter carrying the in-queue flag as its top bit. Depends on rqr_pkg.
module rqr_link_ram #(
  parameter int MAX_TASKS = rqr_pkg::MAX_TASKS_DEF
) (
  input  logic                     clk,
  input  rqr_pkg::rqr_ram_ctl_t    ctl,
  input  logic [$clog2(MAX_TASKS)-1:0]   rd_addr,
  input  logic [$clog2(MAX_TASKS)-1:0]   next_waddr,
  input  logic [$clog2(MAX_TASKS+1)-1:0] next_wdata,
  input  logic [$clog2(MAX_TASKS)-1:0]   prev_waddr,
  input  logic [$clog2(MAX_TASKS+1):0]   prev_wdata,
  output logic [$clog2(MAX_TASKS+1)-1:0] next_rdata,
  output logic [$clog2(MAX_TASKS+1):0]   prev_rdata
);

  localparam int LINK_W = $clog2(MAX_TASKS + 1);

  logic [LINK_W-1:0] next_mem [MAX_TASKS];
  logic [LINK_W:0]   prev_mem [MAX_TASKS];

  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (ctl.rd_en) begin
      next_rdata <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (ctl.rd_en) begin
      prev_rdata <= prev_mem[rd_addr];
    end
  end

endmodule

/* hdl/ready_queue_with_removal.sv */
// Each command is accepted in ST_IDLE and executed in ST_EXEC; its result is registered
// when ST_EXEC executes with the result register free. A new request is taken only after
// the last one has executed; a remove of a task that has a successor also passes through
// ST_FIX for the deferred prev-link write, and a stalled result holds the block in ST_EXEC.
// Reset (rst_n low, synchronous): queue empties, then a clearing pass over all MAX_TASKS
// entries zeroes the in-queue flags; in_ready stays low during that pass.
module ready_queue_with_removal #(
  parameter int MAX_TASKS = rqr_pkg::MAX_TASKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rqr_pkg::rqr_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rqr_pkg::rqr_out_t out_data
);

  localparam int IDX_W  = $clog2(MAX_TASKS);
  localparam int LINK_W = $clog2(MAX_TASKS + 1);
  // Link value that means "no task".
  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_TASKS);

  rqr_pkg::rqr_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] tail_r, tail_nxt;
  logic [LINK_W-1:0] count_r, count_nxt;
  logic [rqr_pkg::CMD_W-1:0]     cmd_r;
  logic [rqr_pkg::TASK_ID_W-1:0] id_r;
  // Deferred prev-link write of a remove: successor address and its new prev.
  logic [IDX_W-1:0]  fix_addr_r, fix_addr_nxt;
  logic [LINK_W-1:0] fix_data_r, fix_data_nxt;
  logic              out_valid_r;
  rqr_pkg::rqr_out_t out_data_r, res;

  rqr_pkg::rqr_ram_ctl_t ram_ctl;
  logic [IDX_W-1:0]  rd_addr, next_waddr, prev_waddr;
  logic [LINK_W-1:0] next_wdata, next_rdata;
  logic [LINK_W:0]   prev_wdata, prev_rdata;

  logic              accept, out_free, do_exec;
  logic              id_ok, flag;
  logic [LINK_W-1:0] id_link, tgt, p_link, n_link;
  logic [IDX_W-1:0]  id_addr;
  logic              push_go, pop_go, rem_go;

  rqr_link_ram #(
    .MAX_TASKS (MAX_TASKS)
  ) u_link_ram (
    .clk        (clk),
    .ctl        (ram_ctl),
    .rd_addr    (rd_addr),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata)
  );

  assign in_ready  = (state_r == rqr_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign do_exec   = (state_r == rqr_pkg::ST_EXEC) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Decode the held request against the link words read at acceptance.
  assign id_ok   = (32'(id_r) < MAX_TASKS);
  assign id_link = LINK_W'(id_r);
  assign id_addr = IDX_W'(id_r);
  assign flag    = prev_rdata[LINK_W];
  assign tgt     = (cmd_r == rqr_pkg::CMD_POP) ? head_r : id_link;
  // The head's prev and the tail's next are not kept up to date; treat them as no task.
  assign p_link  = (tgt == head_r) ? NIL : prev_rdata[LINK_W-1:0];
  assign n_link  = (tgt == tail_r) ? NIL : next_rdata;

  assign push_go = (cmd_r == rqr_pkg::CMD_PUSH) && id_ok && !flag;
  assign pop_go  = (cmd_r == rqr_pkg::CMD_POP) && (head_r != NIL);
  assign rem_go  = (cmd_r == rqr_pkg::CMD_REMOVE) && id_ok && flag;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rqr_pkg::ST_CLEAR: begin
        if (clr_idx_r == IDX_W'(MAX_TASKS - 1)) begin
          state_nxt = rqr_pkg::ST_IDLE;
        end
      end
      rqr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rqr_pkg::ST_EXEC;
        end
      end
      rqr_pkg::ST_EXEC: begin
        if (out_free) begin
          state_nxt = (rem_go && (n_link != NIL)) ? rqr_pkg::ST_FIX : rqr_pkg::ST_IDLE;
        end
      end
      rqr_pkg::ST_FIX: begin
        state_nxt = rqr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rqr_pkg::ST_CLEAR;
      end
    endcase
  end

  // RAM accesses, list pointers and the result.
  always_comb begin
    ram_ctl       = '0;
    ram_ctl.rd_en = accept;
    rd_addr       = (in_data.cmd == rqr_pkg::CMD_POP) ? head_r[IDX_W-1:0]
                                                      : IDX_W'(in_data.task_id);
    next_waddr    = id_addr;
    next_wdata    = id_link;
    prev_waddr    = id_addr;
    prev_wdata    = {1'b0, NIL};
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    clr_idx_nxt   = clr_idx_r;
    fix_addr_nxt  = fix_addr_r;
    fix_data_nxt  = fix_data_r;

    unique case (state_r)
      rqr_pkg::ST_CLEAR: begin
        // Sweep the flag RAM, one entry per cycle.
        ram_ctl.prev_we = 1'b1;
        prev_waddr      = clr_idx_r;
        clr_idx_nxt     = clr_idx_r + IDX_W'(1);
      end
      rqr_pkg::ST_EXEC: begin
        if (do_exec) begin
          priority if (push_go) begin
            // Append: flag the task, link it behind the old tail.
            ram_ctl.prev_we = 1'b1;
            prev_wdata      = {1'b1, tail_r};
            if (tail_r != NIL) begin
              ram_ctl.next_we = 1'b1;
              next_waddr      = tail_r[IDX_W-1:0];
            end else begin
              head_nxt = id_link;
            end
            tail_nxt  = id_link;
            count_nxt = count_r + LINK_W'(1);
          end else if (pop_go) begin
            // Drop the head's flag and advance the head.
            ram_ctl.prev_we = 1'b1;
            prev_waddr      = head_r[IDX_W-1:0];
            head_nxt        = n_link;
            if (n_link == NIL) begin
              tail_nxt = NIL;
            end
            count_nxt = count_r - LINK_W'(1);
          end else if (rem_go) begin
            // Unlink: drop the flag, bridge predecessor to successor.
            ram_ctl.prev_we = 1'b1;
            if (p_link != NIL) begin
              ram_ctl.next_we = 1'b1;
              next_waddr      = p_link[IDX_W-1:0];
              next_wdata      = n_link;
            end else begin
              head_nxt = n_link;
            end
            if (n_link != NIL) begin
              fix_addr_nxt = n_link[IDX_W-1:0];
              fix_data_nxt = p_link;
            end else begin
              tail_nxt = p_link;
            end
            count_nxt = count_r - LINK_W'(1);
          end else begin
            count_nxt = count_r;
          end
        end
      end
      rqr_pkg::ST_FIX: begin
        // Second half of a remove: point the successor back at the predecessor.
        ram_ctl.prev_we = 1'b1;
        prev_waddr      = fix_addr_r;
        prev_wdata      = {1'b1, fix_data_r};
      end
      rqr_pkg::ST_IDLE: begin
        ram_ctl.prev_we = 1'b0;
      end
      default: begin
        ram_ctl.prev_we = 1'b0;
      end
    endcase

    res.accepted     = push_go || pop_go || rem_go;
    res.popped_valid = pop_go;
    res.popped_id    = pop_go ? rqr_pkg::TASK_ID_W'(head_r) : '0;
    res.queue_count  = rqr_pkg::COUNT_OUT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rqr_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      head_r      <= NIL;
      tail_r      <= NIL;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      if (do_exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request hold, deferred write and result registers carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.cmd;
      id_r  <= in_data.task_id;
    end
    fix_addr_r <= fix_addr_nxt;
    fix_data_r <= fix_data_nxt;
    if (do_exec) begin
      out_data_r <= res;
    end
  end

endmodule

/* hdl/rqr_checker.sv */
// Port-level checks for ready_queue_with_removal, attached by bind.
// Depends on rqr_pkg and the top-level port list.
module rqr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input rqr_pkg::rqr_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input rqr_pkg::rqr_out_t out_data
);

  // Reset empties the result register.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One request at a time: no acceptance in the cycle after one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted back to back");

  // A returned task always counts as a change to the queue.
  a_pop_implies_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.popped_valid |-> out_data.accepted)
    else $error("popped task without accepted");

  // Without a returned task the popped id reads zero.
  a_popped_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.popped_valid |-> out_data.popped_id == '0)
    else $error("popped id nonzero without pop");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind ready_queue_with_removal rqr_checker u_rqr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/ready_queue_with_removal_tb.sv */
// Testbench for ready_queue_with_removal: directed table and shaped random requests,
// each result checked against a linked-list model of the queue kept here.
// Depends on rqr_pkg (payload structs, command codes) and the block itself.
`timescale 1ns / 1ps

module ready_queue_with_removal_tb;

  localparam logic [rqr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [6:0]       NIL         = 7'd64;
  localparam int               N_DIRECTED  = 25;
  localparam int               N_RANDOM    = 1430;
  localparam int               BLOCK_LEN   = 50;
  localparam int               DRAIN_WAIT  = 20;
  localparam int               STALL_LIMIT = 5000;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } mix_mode_t;

  // One directed row: the request, whether a typed-in result applies, and that result.
  typedef struct packed {
    rqr_pkg::rqr_in_t  req;
    logic              fixed;
    rqr_pkg::rqr_out_t want;
  } dir_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  rqr_pkg::rqr_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rqr_pkg::rqr_out_t out_data;

  // Queue model: link tables, membership flags, head, tail and count.
  logic [6:0] q_next [64];
  logic [6:0] q_prev [64];
  bit         q_member [64];
  logic [6:0] q_head;
  logic [6:0] q_tail;
  logic [6:0] q_count;

  rqr_pkg::rqr_out_t pending_results [$];
  rqr_pkg::rqr_out_t oldest_result;
  int         fail_count   = 0;
  int         stall_cycles = 0;
  bit         calm         = 1'b0;

  // Directed table: typed results where they are plain; zero-filled rows use the model.
  dir_row_t directed_rows [N_DIRECTED] = '{
    // pop of an empty queue, task field ignored
    {rqr_pkg::CMD_POP,    6'd63, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0},
    // remove of a task that is not queued
    {rqr_pkg::CMD_REMOVE, 6'd5,  1'b1, 1'b0, 1'b0, 6'd0, 7'd0},
    // unused command code
    {CMD_UNUSED,          6'd63, 1'b1, 1'b0, 1'b0, 6'd0, 7'd0},
    {rqr_pkg::CMD_PUSH,   6'd0,  1'b1, 1'b1, 1'b0, 6'd0, 7'd1},
    {rqr_pkg::CMD_PUSH,   6'd63, 1'b1, 1'b1, 1'b0, 6'd0, 7'd2},
    // push of a task already queued
    {rqr_pkg::CMD_PUSH,   6'd63, 1'b1, 1'b0, 1'b0, 6'd0, 7'd2},
    {rqr_pkg::CMD_PUSH,   6'd21, 1'b1, 1'b1, 1'b0, 6'd0, 7'd3},
    {rqr_pkg::CMD_PUSH,   6'd42, 1'b1, 1'b1, 1'b0, 6'd0, 7'd4},
    // remove from the middle, then from the tail
    {rqr_pkg::CMD_REMOVE, 6'd21, 1'b1, 1'b1, 1'b0, 6'd0, 7'd3},
    {rqr_pkg::CMD_REMOVE, 6'd42, 1'b1, 1'b1, 1'b0, 6'd0, 7'd2},
    {rqr_pkg::CMD_PUSH,   6'd42, 1'b0, 15'd0},
    // remove the head
    {rqr_pkg::CMD_REMOVE, 6'd0,  1'b0, 15'd0},
    {rqr_pkg::CMD_POP,    6'd0,  1'b0, 15'd0},
    {rqr_pkg::CMD_POP,    6'd21, 1'b0, 15'd0},
    {rqr_pkg::CMD_POP,    6'd0,  1'b1, 1'b0, 1'b0, 6'd0, 7'd0},
    // remove the only entry, then again once it is gone
    {rqr_pkg::CMD_PUSH,   6'd7,  1'b0, 15'd0},
    {rqr_pkg::CMD_REMOVE, 6'd7,  1'b0, 15'd0},
    {rqr_pkg::CMD_REMOVE, 6'd7,  1'b1, 1'b0, 1'b0, 6'd0, 7'd0},
    // reuse of a popped task, whose links were cleared
    {rqr_pkg::CMD_PUSH,   6'd7,  1'b0, 15'd0},
    {rqr_pkg::CMD_PUSH,   6'd8,  1'b0, 15'd0},
    {rqr_pkg::CMD_POP,    6'd63, 1'b0, 15'd0},
    {rqr_pkg::CMD_PUSH,   6'd7,  1'b0, 15'd0},
    {rqr_pkg::CMD_POP,    6'd0,  1'b0, 15'd0},
    {rqr_pkg::CMD_POP,    6'd0,  1'b0, 15'd0},
    {CMD_UNUSED,          6'd0,  1'b1, 1'b0, 1'b0, 6'd0, 7'd0}
  };

  ready_queue_with_removal u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the queue model and return the result it should produce.
  function automatic rqr_pkg::rqr_out_t ready_queue_update(rqr_pkg::rqr_in_t req);
    rqr_pkg::rqr_out_t res;
    logic [5:0] t;
    logic [6:0] p;
    logic [6:0] n;
    res = '0;
    t   = req.task_id;
    case (req.cmd)
      rqr_pkg::CMD_PUSH: begin
        if (!q_member[t]) begin
          q_member[t] = 1'b1;
          q_next[t]   = NIL;
          q_prev[t]   = q_tail;
          if (q_tail != NIL) q_next[q_tail[5:0]] = {1'b0, t};
          else q_head = {1'b0, t};
          q_tail       = {1'b0, t};
          q_count      = q_count + 7'd1;
          res.accepted = 1'b1;
        end
      end
      rqr_pkg::CMD_POP: begin
        if (q_head != NIL) begin
          t           = q_head[5:0];
          q_member[t] = 1'b0;
          q_head      = q_next[t];
          if (q_head != NIL) q_prev[q_head[5:0]] = NIL;
          else q_tail = NIL;
          q_next[t]        = NIL;
          q_prev[t]        = NIL;
          q_count          = q_count - 7'd1;
          res.accepted     = 1'b1;
          res.popped_valid = 1'b1;
          res.popped_id    = t;
        end
      end
      rqr_pkg::CMD_REMOVE: begin
        if (q_member[t]) begin
          q_member[t] = 1'b0;
          p           = q_prev[t];
          n           = q_next[t];
          if (p != NIL) q_next[p[5:0]] = n;
          else q_head = n;
          if (n != NIL) q_prev[n[5:0]] = p;
          else q_tail = p;
          q_next[t]    = NIL;
          q_prev[t]    = NIL;
          q_count      = q_count - 7'd1;
          res.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    res.queue_count = q_count;
    return res;
  endfunction

  // Pick a task whose membership matches; fall back to a random one if none does.
  function automatic logic [5:0] pick_task(bit want_queued);
    logic [5:0] idx;
    idx = 6'($urandom_range(0, 63));
    repeat (64) begin
      if (q_member[idx] == want_queued) return idx;
      idx = idx + 6'd1;
    end
    return idx;
  endfunction

  // Offer one request: idle at random, hold valid and payload until the handshake,
  // then record what the queue should answer.
  task automatic send_request(rqr_pkg::rqr_in_t req, logic fixed, rqr_pkg::rqr_out_t want);
    rqr_pkg::rqr_out_t predicted;
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = ready_queue_update(req);
    pending_results.insert(pending_results.size(), fixed ? want : predicted);
  endtask

  // Stall the result side in about a quarter of the cycles, except in the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(0, 99) >= 25);
  end

  // Compare each accepted result with the oldest pending one, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: %h", out_data);
        fail_count++;
      end else begin
        oldest_result = pending_results[0];
        pending_results.delete(0);
        if (out_data.accepted !== oldest_result.accepted) begin
          $error("accepted: expected %0d, got %0d", oldest_result.accepted,
                 out_data.accepted);
          fail_count++;
        end
        if (out_data.popped_valid !== oldest_result.popped_valid) begin
          $error("popped_valid: expected %0d, got %0d", oldest_result.popped_valid,
                 out_data.popped_valid);
          fail_count++;
        end
        if (out_data.popped_id !== oldest_result.popped_id) begin
          $error("popped_id: expected %0d, got %0d", oldest_result.popped_id,
                 out_data.popped_id);
          fail_count++;
        end
        if (out_data.queue_count !== oldest_result.queue_count) begin
          $error("queue_count: expected %0d, got %0d", oldest_result.queue_count,
                 out_data.queue_count);
          fail_count++;
        end
      end
    end
  end

  // Count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $error("no progress for %0d cycles", STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    rqr_pkg::rqr_in_t req;
    mix_mode_t mode;
    int        roll;
    int        push_pct;
    int        pop_pct;
    int        remove_pct;

    // Start the model empty, matching the block after its clearing pass.
    for (int i = 0; i < 64; i++) begin
      q_next[i]   = NIL;
      q_prev[i]   = NIL;
      q_member[i] = 1'b0;
    end
    q_head  = NIL;
    q_tail  = NIL;
    q_count = 7'd0;
    mode    = MODE_MIX;

    // Hold reset low at start-up, then release it once.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table.
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_request(directed_rows[r].req, directed_rows[r].fixed, directed_rows[r].want);
    end

    // Random requests in blocks of one mix each; blocks two and three fill the queue
    // so that the full case is reached. Most requests are well formed (push of a free
    // task, remove of a queued one); the rest are noise.
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % BLOCK_LEN == 0) begin
        if (k / BLOCK_LEN == 2 || k / BLOCK_LEN == 3) mode = MODE_FILL;
        else mode = mix_mode_t'($urandom_range(0, 2));
      end
      // Drop idling on both sides for one long stretch.
      calm = (k >= 700 && k < 900);
      case (mode)
        MODE_FILL: begin
          push_pct = 85;
          pop_pct  = 5;
          remove_pct = 5;
        end
        MODE_DRAIN: begin
          push_pct = 10;
          pop_pct  = 55;
          remove_pct = 30;
        end
        default: begin
          push_pct = 40;
          pop_pct  = 25;
          remove_pct = 30;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        req.cmd     = rqr_pkg::CMD_PUSH;
        req.task_id = pick_task(1'b0);
      end else if (roll < push_pct + pop_pct) begin
        req.cmd     = rqr_pkg::CMD_POP;
        req.task_id = 6'($urandom_range(0, 63));
      end else if (roll < push_pct + pop_pct + remove_pct) begin
        req.cmd     = rqr_pkg::CMD_REMOVE;
        req.task_id = pick_task(1'b1);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            req.cmd     = CMD_UNUSED;
            req.task_id = 6'($urandom_range(0, 63));
          end
          1: begin
            req.cmd     = rqr_pkg::CMD_PUSH;
            req.task_id = pick_task(1'b1);
          end
          default: begin
            req.cmd     = rqr_pkg::CMD_REMOVE;
            req.task_id = pick_task(1'b0);
          end
        endcase
      end
      send_request(req, 1'b0, '0);
    end
    calm = 1'b0;

    // Release the input, wait out every pending result, then the tail latency.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
